// ----- src/dtc_debounce_status_manager_assert.svh -----
`ifndef DTC_DEBOUNCE_STATUS_MANAGER_ASSERT_SVH
`define DTC_DEBOUNCE_STATUS_MANAGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtc_debounce_status_manager: check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtc_debounce_status_manager: check failed");

`endif

// ----- src/dtc_pkg.sv -----
package dtc_pkg;

  // default slot count
  localparam int unsigned SLOTS_DEFAULT = 32;

  // request opcodes
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_SET    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FAIL_COUNT_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_TIME_LIMIT        = 3'd1;
  localparam logic [2:0] CFG_AGING_THRESHOLD   = 3'd2;
  localparam logic [2:0] CFG_HEALING_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_VITAL_EVENT_ID    = 3'd4;

  // configuration reset values
  localparam logic [15:0] FAIL_COUNT_LIMIT_RST  = 16'd5;
  localparam logic [15:0] TIME_LIMIT_RST        = 16'd10;
  localparam logic [15:0] AGING_THRESHOLD_RST   = 16'd40;
  localparam logic [7:0]  HEALING_THRESHOLD_RST = 8'd3;
  localparam logic [15:0] VITAL_EVENT_ID_RST    = 16'd0;

  // uds status bits
  localparam logic [7:0] UDS_TF     = 8'h01;
  localparam logic [7:0] UDS_TFTOC  = 8'h02;
  localparam logic [7:0] UDS_PDTC   = 8'h04;
  localparam logic [7:0] UDS_CDTC   = 8'h08;
  localparam logic [7:0] UDS_TNCSLC = 8'h10;
  localparam logic [7:0] UDS_TFSLC  = 8'h20;
  localparam logic [7:0] UDS_TNCTOC = 8'h40;
  localparam logic [7:0] UDS_WIR    = 8'h80;

  // warning-raising identifier range and severities
  localparam logic [15:0] FAULT_LO     = 16'hF100;
  localparam logic [15:0] FAULT_HI     = 16'hF1FF;
  localparam logic [1:0]  SEV_CRIT     = 2'd3;
  localparam logic [1:0]  SEV_LOW      = 2'd0;
  localparam logic [7:0]  PASSED_MAX   = 8'hFF;
  localparam logic [15:0] AGING_MAX    = 16'hFFFF;

  // configuration set
  typedef struct packed {
    logic [15:0] fail_count_limit;
    logic [15:0] time_limit;
    logic [15:0] aging_threshold;
    logic [7:0]  healing_threshold;
    logic [15:0] vital_event_id;
  } cfg_t;

  // one slot of the table
  typedef struct packed {
    logic [7:0]  status_bits;
    logic [15:0] aging_count;
    logic [7:0]  passed_count;
    logic [15:0] fail_sample_count;
    logic [15:0] fail_time_count;
  } slot_row_t;

  // one result
  typedef struct packed {
    logic [7:0] status_byte;
    logic       log_valid;
    logic [1:0] log_severity;
    logic       log_passed;
  } result_t;

  // slot table access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ----- src/dtc_slot_mod.sv -----
module dtc_slot_mod #(
  parameter int unsigned SLOTS = dtc_pkg::SLOTS_DEFAULT,
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [15:0]   id_i,
  output logic          done_o,
  output logic [SW-1:0] slot_o
);

  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned RW  = CW + 1;
  localparam int unsigned PQW = 17 + CW;
  localparam logic [24:0] RECIP   = 25'((2 ** 24) / SLOTS);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [40:0]    prod_r;
  logic [RW-1:0]  rem_r;
  logic [2:0]     vld_r;
  logic [16:0]    quot;
  logic [PQW-1:0] qs;
  logic [PQW-1:0] rem_full;
  logic [RW-1:0]  rem_fix;

  // quotient estimate by reciprocal, at most one below the true quotient
  always_ff @(posedge clk) begin
    prod_r <= 41'(id_i) * 41'(RECIP);
    rem_r  <= rem_full[RW-1:0];
  end

  assign quot     = prod_r[40:24];
  assign qs       = PQW'(quot) * PQW'(SLOTS_C);
  assign rem_full = PQW'(id_i) - qs;

  // final correction step
  assign rem_fix = (rem_r >= RW'(SLOTS)) ? (rem_r - RW'(SLOTS)) : rem_r;
  assign slot_o  = rem_fix[SW-1:0];

  // latency tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start_i};
    end
  end

  assign done_o = vld_r[2];

endmodule

// ----- src/dtc_slot_store.sv -----
module dtc_slot_store #(
  parameter int unsigned SLOTS = dtc_pkg::SLOTS_DEFAULT,
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dtc_pkg::mem_ctl_t   ctl_i,
  input  logic [SW-1:0]       rd_addr_i,
  input  logic [SW-1:0]       wr_addr_i,
  input  dtc_pkg::slot_row_t  wr_row_i,
  output dtc_pkg::slot_row_t  rd_row_o
);

  dtc_pkg::slot_row_t mem [SLOTS];
  dtc_pkg::slot_row_t rd_row_r;
  logic [SLOTS-1:0]   valid_r;
  logic               rd_valid_r;

  // table write
  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (ctl_i.rd_en) begin
      rd_row_r <= mem[rd_addr_i];
    end
  end

  // per-slot written flags, a slot never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_valid_r <= valid_r[rd_addr_i];
      end
      if (ctl_i.wr_en) begin
        valid_r[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_row_o = rd_valid_r ? rd_row_r : '0;

endmodule

// ----- src/dtc_slot_alu.sv -----
module dtc_slot_alu (
  input  dtc_pkg::op_t        op_i,
  input  logic [15:0]         id_i,
  input  logic                raw_i,
  input  dtc_pkg::cfg_t       cfg_i,
  input  dtc_pkg::slot_row_t  row_i,
  output dtc_pkg::slot_row_t  row_o,
  output dtc_pkg::result_t    res_o
);

  logic        fault_id;
  logic        vital;
  logic [15:0] fsc_n;
  logic [15:0] aging_n;

  // confirmed failure
  function automatic dtc_pkg::slot_row_t fail_row(dtc_pkg::slot_row_t r, logic fault);
    dtc_pkg::slot_row_t o;
    o = r;
    o.status_bits = o.status_bits | dtc_pkg::UDS_TF | dtc_pkg::UDS_TFTOC |
                    dtc_pkg::UDS_PDTC | dtc_pkg::UDS_CDTC | dtc_pkg::UDS_TFSLC;
    o.status_bits = o.status_bits & ~(dtc_pkg::UDS_TNCSLC | dtc_pkg::UDS_TNCTOC);
    if (fault) begin
      o.status_bits  = o.status_bits | dtc_pkg::UDS_WIR;
      o.aging_count  = '0;
      o.passed_count = '0;
    end
    return o;
  endfunction

  // recovery
  function automatic dtc_pkg::slot_row_t pass_row(dtc_pkg::slot_row_t r);
    dtc_pkg::slot_row_t o;
    o = r;
    o.status_bits = o.status_bits & ~dtc_pkg::UDS_TF;
    if (o.passed_count != dtc_pkg::PASSED_MAX) begin
      o.passed_count = o.passed_count + 8'd1;
    end
    return o;
  endfunction

  assign fault_id = (id_i >= dtc_pkg::FAULT_LO) && (id_i <= dtc_pkg::FAULT_HI);
  assign vital    = (id_i == cfg_i.vital_event_id);
  assign fsc_n    = (row_i.fail_sample_count < cfg_i.fail_count_limit) ?
                    (row_i.fail_sample_count + 16'd1) : row_i.fail_sample_count;
  assign aging_n  = (row_i.aging_count != dtc_pkg::AGING_MAX) ?
                    (row_i.aging_count + 16'd1) : row_i.aging_count;

  // one slot read-modify-write
  always_comb begin
    row_o = row_i;
    res_o = '0;
    unique case (op_i)
      dtc_pkg::OP_REPORT: begin
        if (vital && raw_i) begin
          row_o = fail_row(row_i, fault_id);
          res_o.log_valid    = 1'b1;
          res_o.log_severity = dtc_pkg::SEV_CRIT;
        end else if (raw_i) begin
          row_o.fail_sample_count = fsc_n;
          if (fsc_n >= cfg_i.fail_count_limit) begin
            if (row_i.fail_time_count < cfg_i.time_limit) begin
              row_o.fail_time_count = row_i.fail_time_count + 16'd1;
            end else begin
              row_o = fail_row(row_o, fault_id);
              res_o.log_valid    = 1'b1;
              res_o.log_severity = dtc_pkg::SEV_CRIT;
            end
          end
        end else begin
          row_o.fail_sample_count = '0;
          row_o.fail_time_count   = '0;
          row_o = pass_row(row_o);
          res_o.log_valid    = 1'b1;
          res_o.log_severity = dtc_pkg::SEV_LOW;
          res_o.log_passed   = 1'b1;
        end
        res_o.status_byte = row_o.status_bits;
      end
      dtc_pkg::OP_SET: begin
        if (raw_i) begin
          row_o = fail_row(row_i, fault_id);
          res_o.log_severity = dtc_pkg::SEV_CRIT;
        end else begin
          row_o = pass_row(row_i);
          res_o.log_severity = dtc_pkg::SEV_LOW;
          res_o.log_passed   = 1'b1;
        end
        res_o.log_valid   = 1'b1;
        res_o.status_byte = row_o.status_bits;
      end
      dtc_pkg::OP_TICK: begin
        // aging of a stored but no longer failing fault
        if (((row_i.status_bits & dtc_pkg::UDS_TF) == 8'd0) &&
            ((row_i.status_bits & dtc_pkg::UDS_PDTC) != 8'd0)) begin
          row_o.aging_count = aging_n;
          if (aging_n >= cfg_i.aging_threshold) begin
            row_o.status_bits = '0;
            row_o.aging_count = '0;
          end
        end
        // warning indicator healing
        if (row_i.passed_count >= cfg_i.healing_threshold) begin
          row_o.status_bits = row_o.status_bits & ~dtc_pkg::UDS_WIR;
        end
      end
      dtc_pkg::OP_NONE: begin
        row_o = row_i;
      end
    endcase
  end

endmodule

// ----- src/dtc_debounce_status_manager.sv -----
// Diagnostic status manager with debounce and aging. A request is taken when start is high
// and busy is low; every request gives exactly one result, shown for a single cycle with
// out_strobe high, and the receiver must take it then since there is no back-pressure.
// A report or direct set shows its result after the slot number (event id modulo SLOTS by
// reciprocal multiply and remainder), then the final correction with the registered table
// read, then the update and write-back. A cycle tick walks the whole table through the
// same update unit, reading each slot and then writing it back, and shows its result once
// the last slot is written back. An unused opcode answers in the next cycle. busy falls in
// the cycle the result is shown, so the next request may be given then. The configuration
// port is always ready and should only be written while no request is in flight.
module dtc_debounce_status_manager #(
  parameter int unsigned SLOTS = dtc_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_event_id,
  input  logic        in_raw_signal,
  output logic        out_strobe,
  output logic [7:0]  out_status_byte,
  output logic        out_log_valid,
  output logic [1:0]  out_log_severity,
  output logic        out_log_passed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "dtc_debounce_status_manager_assert.svh"

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOD  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_TRD  = 5'b01000,
    ST_TUPD = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic               strobe_r, strobe_nxt;
  dtc_pkg::result_t   res_r, res_nxt;
  dtc_pkg::op_t       op_r;
  logic [15:0]        id_r;
  logic               raw_r;
  dtc_pkg::cfg_t      cfg_r;
  dtc_pkg::mem_ctl_t  mem_ctl;
  logic               mod_start;
  logic               mod_done;
  logic [SW-1:0]      mod_slot;
  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      wr_addr;
  dtc_pkg::slot_row_t rd_row;
  dtc_pkg::slot_row_t new_row;
  dtc_pkg::result_t   alu_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_count_limit  <= dtc_pkg::FAIL_COUNT_LIMIT_RST;
      cfg_r.time_limit        <= dtc_pkg::TIME_LIMIT_RST;
      cfg_r.aging_threshold   <= dtc_pkg::AGING_THRESHOLD_RST;
      cfg_r.healing_threshold <= dtc_pkg::HEALING_THRESHOLD_RST;
      cfg_r.vital_event_id    <= dtc_pkg::VITAL_EVENT_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dtc_pkg::CFG_FAIL_COUNT_LIMIT:  cfg_r.fail_count_limit  <= cfg_data;
        dtc_pkg::CFG_TIME_LIMIT:        cfg_r.time_limit        <= cfg_data;
        dtc_pkg::CFG_AGING_THRESHOLD:   cfg_r.aging_threshold   <= cfg_data;
        dtc_pkg::CFG_HEALING_THRESHOLD: cfg_r.healing_threshold <= cfg_data[7:0];
        dtc_pkg::CFG_VITAL_EVENT_ID:    cfg_r.vital_event_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r  <= dtc_pkg::op_t'(in_opcode);
      id_r  <= in_event_id;
      raw_r <= in_raw_signal;
    end
  end

  // slot number unit
  dtc_slot_mod #(.SLOTS(SLOTS)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mod_start),
    .id_i    (id_r),
    .done_o  (mod_done),
    .slot_o  (mod_slot)
  );

  // slot table
  dtc_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_row_i  (new_row),
    .rd_row_o  (rd_row)
  );

  // shared slot update unit
  dtc_slot_alu u_alu (
    .op_i  (op_r),
    .id_i  (id_r),
    .raw_i (raw_r),
    .cfg_i (cfg_r),
    .row_i (rd_row),
    .row_o (new_row),
    .res_o (alu_res)
  );

  assign rd_addr = (state_r == ST_MOD) ? mod_slot : idx_r;
  assign wr_addr = (state_r == ST_UPD) ? slot_r : idx_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    mem_ctl    = '0;
    mod_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (dtc_pkg::op_t'(in_opcode))
            dtc_pkg::OP_REPORT, dtc_pkg::OP_SET: begin
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
            dtc_pkg::OP_TICK: begin
              idx_nxt   = '0;
              state_nxt = ST_TRD;
            end
            dtc_pkg::OP_NONE: begin
              strobe_nxt = 1'b1;
              res_nxt    = '0;
            end
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          mem_ctl.rd_en = 1'b1;
          slot_nxt      = mod_slot;
          state_nxt     = ST_UPD;
        end
      end
      ST_UPD: begin
        mem_ctl.wr_en = 1'b1;
        strobe_nxt    = 1'b1;
        res_nxt       = alu_res;
        state_nxt     = ST_IDLE;
      end
      ST_TRD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = ST_TUPD;
      end
      ST_TUPD: begin
        mem_ctl.wr_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          strobe_nxt = 1'b1;
          res_nxt    = '0;
          state_nxt  = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = ST_TRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
  end

  // result ports
  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_status_byte  = res_r.status_byte;
  assign out_log_valid    = res_r.log_valid;
  assign out_log_severity = res_r.log_severity;
  assign out_log_passed   = res_r.log_passed;

  // checks
  `DTC_ASSERT_NEXT(a_report_starts_mod,
    (state_r == ST_IDLE && start && in_opcode == dtc_pkg::OP_REPORT), (state_r == ST_MOD))
  `DTC_ASSERT_NOW(a_mod_done_in_mod, mod_done, (state_r == ST_MOD))
  `DTC_ASSERT_NOW(a_write_in_update, mem_ctl.wr_en,
    (state_r == ST_UPD || state_r == ST_TUPD))
  `DTC_ASSERT_NEXT(a_tick_result_zero, (state_r == ST_TUPD && idx_r == LAST_IDX),
    (out_strobe && out_status_byte == 8'd0 && !out_log_valid))

endmodule
